### sv/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared widths, constants and types for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int PV_W    = 15;
    localparam int PEND_W  = 2;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [CP_W-1:0] REPLACEMENT = CP_W'(24'h00FFFD);

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            invalid;
        logic            last;
    } t_res;

    // results handed from the decode stage to the output queue
    typedef struct packed {
        logic [1:0] n;
        t_res       res0;
        t_res       res1;
    } t_push;

    // output queue status seen by the decode stage
    typedef struct packed {
        logic [Q_CW-1:0] cnt;
        logic            room2;
    } t_q_stat;

endpackage

`default_nettype wire

### sv/u8sd_if.sv
// ----------------------------------------------------------------------------
// u8sd_if
// Valid/ready channels for raw bytes in and decoded code points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8sd_byte_if;
    import u8sd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8sd_cp_if;
    import u8sd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            invalid;
    logic            last;

    modport source (output valid, output code_point, output invalid, output last,
                    input ready);
    modport sink   (input valid, input code_point, input invalid, input last,
                    output ready);
endinterface

`default_nettype wire

### sv/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Byte-serial UTF-8 decoder with valid/ready channels on both sides.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and returns code points with an invalid flag and
// a last flag marking the final result of each byte. A byte is held in an
// input register and decoded from there into zero, one or two results,
// which go into a four-entry output queue. Sustained rate is one byte per
// cycle as long as results are taken; a byte that truncates a sequence and
// yields two results hands them out one at a time, so the output port sets
// the rate then. The decode stage fires only when the queue has room for two
// results.
`default_nettype none

module utf8_stream_decoder_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    u8sd_byte_if.sink i_byte,
    u8sd_cp_if.source o_cp
);
    import u8sd_pkg::*;

    t_push   push;
    t_q_stat qstat;

    u8sd_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_qstat (qstat),
        .o_push  (push)
    );

    u8sd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_qstat (qstat),
        .o_cp    (o_cp)
    );

`ifndef SYNTHESIS
    a_valid_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cp.valid && !o_cp.invalid |-> o_cp.last)
        else $error("good code point without last flag");

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.cnt <= Q_CW'(Q_DEPTH))
        else $error("output queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.n != 2'd0 |-> qstat.room2)
        else $error("push without queue room");

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_cp.valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

### sv/u8sd_dec.sv
// ----------------------------------------------------------------------------
// u8sd_dec
// Input byte register, sequence state and single-pass decode of one byte
// into zero, one or two results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_dec (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    u8sd_byte_if.sink          i_byte,
    input  wire u8sd_pkg::t_q_stat i_qstat,
    output u8sd_pkg::t_push    o_push
);
    import u8sd_pkg::*;

    typedef struct packed {
        logic              emit;
        t_res              res;
        logic [PEND_W-1:0] pend;
        logic [PV_W-1:0]   pv;
    } t_idle;

    function automatic t_idle idle_decode(input logic [BYTE_W-1:0] b);
        t_idle r;
        r            = '0;
        r.res.last   = 1'b1;
        case (b) inside
            8'b0???????: begin
                r.emit           = 1'b1;
                r.res.code_point = CP_W'(b);
            end
            8'b110?????: begin
                r.pend = PEND_W'(1);
                r.pv   = PV_W'(b[4:0]);
            end
            8'b1110????: begin
                r.pend = PEND_W'(2);
                r.pv   = PV_W'(b[3:0]);
            end
            8'b11110???: begin
                r.pend = PEND_W'(3);
                r.pv   = PV_W'(b[2:0]);
            end
            default: begin
                r.emit           = 1'b1;
                r.res.code_point = REPLACEMENT;
                r.res.invalid    = 1'b1;
            end
        endcase
        return r;
    endfunction

    logic              r_vld;
    logic [BYTE_W-1:0] r_byte;
    logic [PV_W-1:0]   r_pv;
    logic [PEND_W-1:0] r_pend;

    logic              n_vld;
    logic [PV_W-1:0]   n_pv;
    logic [PEND_W-1:0] n_pend;

    logic              fire;
    logic              accept;
    t_idle             idl;
    t_push             dec;
    logic [CP_W-1:0]   acc;
    logic [PEND_W-1:0] pend_dec;

    assign fire           = r_vld && i_qstat.room2;
    assign i_byte.ready   = !r_vld || fire;
    assign accept         = i_byte.valid && i_byte.ready;

    always_comb begin
        idl      = idle_decode(r_byte);
        acc      = {r_pv, r_byte[5:0]};
        pend_dec = r_pend - PEND_W'(1);
        dec      = '0;
        n_pv     = r_pv;
        n_pend   = r_pend;
        if (r_pend == '0) begin
            dec.n    = {1'b0, idl.emit};
            dec.res0 = idl.res;
            n_pend   = idl.pend;
            if (idl.pend != '0) begin
                n_pv = idl.pv;
            end
        end else if (r_byte[7:6] == 2'b10) begin
            n_pend = pend_dec;
            if (pend_dec == '0) begin
                dec.n               = 2'd1;
                dec.res0.code_point = acc;
                dec.res0.last       = 1'b1;
                n_pv                = '0;
            end else begin
                n_pv = acc[PV_W-1:0];
            end
        end else begin
            // truncated sequence, then the byte again as a fresh one
            dec.res0.code_point = REPLACEMENT;
            dec.res0.invalid    = 1'b1;
            dec.res0.last       = !idl.emit;
            dec.res1            = idl.res;
            dec.n               = idl.emit ? 2'd2 : 2'd1;
            n_pend              = idl.pend;
            n_pv                = (idl.pend != '0) ? idl.pv : '0;
        end
        o_push = dec;
        if (!fire) begin
            o_push.n = 2'd0;
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (fire) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_pv   <= '0;
            r_pend <= '0;
        end else begin
            r_vld <= n_vld;
            if (fire) begin
                r_pv   <= n_pv;
                r_pend <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte.in_byte;
        end
    end

endmodule

`default_nettype wire

### sv/u8sd_outq.sv
// ----------------------------------------------------------------------------
// u8sd_outq
// Small result queue that takes up to two results a cycle and hands out
// one a cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_outq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire u8sd_pkg::t_push i_push,
    output u8sd_pkg::t_q_stat  o_qstat,
    u8sd_cp_if.source          o_cp
);
    import u8sd_pkg::*;

    t_res            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    logic [Q_AW-1:0] n_wp;
    logic [Q_AW-1:0] n_rp;
    logic [Q_CW-1:0] n_cnt;

    logic            pop;
    logic [Q_AW-1:0] wp1;

    assign pop           = o_cp.valid && o_cp.ready;
    assign wp1           = r_wp + Q_AW'(1);
    assign o_cp.valid    = (r_cnt != '0);
    assign o_cp.code_point = r_mem[r_rp].code_point;
    assign o_cp.invalid  = r_mem[r_rp].invalid;
    assign o_cp.last     = r_mem[r_rp].last;

    always_comb begin
        o_qstat.cnt   = r_cnt;
        o_qstat.room2 = (r_cnt <= Q_CW'(Q_DEPTH - 2))
                     || ((r_cnt == Q_CW'(Q_DEPTH - 1)) && pop);
        n_wp  = r_wp + Q_AW'(i_push.n);
        n_rp  = r_rp + Q_AW'(pop);
        n_cnt = r_cnt + Q_CW'(i_push.n) - Q_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wp1] <= i_push.res1;
        end
    end

endmodule

`default_nettype wire
